### sv/assert_macros.svh
// Assertion macros used by the controller of the shear interpolation core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### sv/irsi_pkg.sv
// Package with the constants and command type of the shear interpolation core.
`timescale 1ns / 1ps
`default_nettype none

package irsi_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int ONE_Q14    = 1 << FRAC_BITS;
  localparam int SHEAR_W    = 16;
  localparam int DIM_W      = 13;
  localparam int COL_W      = 12;
  localparam int PIX_IO_W   = 8;
  localparam int PROD_W     = 29;
  localparam int SW         = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SHEAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic capture;
    logic load;
    logic mul;
    logic shift;
    logic bound;
    logic addr;
    logic rd_a;
    logic rd_b;
    logic mix;
    logic out_load;
  } irsi_cmd_t;

endpackage

`default_nettype wire

### sv/irsi_dpath.sv
// Datapath of the shear interpolation core: row buffer, shift arithmetic and mixer.
`timescale 1ns / 1ps
`default_nettype none

module irsi_dpath import irsi_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                       clk_i,
  input  wire irsi_cmd_t                  cmd_i,
  input  wire logic [COL_W-1:0]           column_i,
  input  wire logic [COL_W-1:0]           row_i,
  input  wire logic [PIX_IO_W-1:0]        pixel_in_i,
  input  wire logic signed [SHEAR_W-1:0]  shear_factor_i,
  input  wire logic [DIM_W-1:0]           row_width_i,
  input  wire logic [DIM_W-1:0]           image_height_i,
  output logic [PIX_IO_W-1:0]             pixel_out_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = ((AW > COL_W) ? AW : COL_W) + 1;
  localparam int PW = PIXEL_BITS;

  logic [PW-1:0] mem [MAX_WIDTH];

  logic [COL_W-1:0]         column_q, row_q;
  logic signed [PROD_W-1:0] dr_q;
  logic [DIM_W-1:0]         w_q;
  logic [FRAC_BITS-1:0]     frac_q;
  logic signed [SW-1:0]     di_q, lo_q, hi_q;
  logic [AW-1:0]            addr_q;
  logic [PW-1:0]            rdata_q, a_q;
  logic signed [PW+15:0]    prod_q;
  logic [PIX_IO_W-1:0]      pixel_out_q;

  // Load path straight from the input port.
  logic [CW-1:0]    col_ext;
  logic             in_range;
  logic [PW+7:0]    pin_wide;
  logic [PW-1:0]    wdata;
  logic             we;

  assign col_ext  = CW'(column_i);
  assign in_range = col_ext < CW'(MAX_WIDTH);
  assign pin_wide = {{PW{1'b0}}, pixel_in_i};
  assign wdata    = pin_wide[PW-1:0];
  assign we       = cmd_i.load && in_range;

  // Shift product and clamped width.
  logic [COL_W-1:0]         centre;
  logic signed [DIM_W-1:0]  row_diff;
  logic signed [PROD_W-1:0] dr_d;
  logic [DIM_W-1:0]         w_d;

  assign centre   = image_height_i[DIM_W-1:1];
  assign row_diff = $signed({1'b0, row_q}) - $signed({1'b0, centre});
  assign dr_d     = row_diff * shear_factor_i;

  always_comb begin
    if (row_width_i < DIM_W'(2)) begin
      w_d = DIM_W'(2);
    end else if ((CW + 4)'(row_width_i) > (CW + 4)'(MAX_WIDTH)) begin
      w_d = DIM_W'(MAX_WIDTH);
    end else begin
      w_d = row_width_i;
    end
  end

  // Whole shift clamped so that the valid span keeps at least one column.
  logic signed [SW-1:0] w_s, di_raw, di_d, lo_d, hi_d;

  assign w_s    = $signed(SW'(w_q));
  assign di_raw = SW'($signed(dr_q[PROD_W-1:FRAC_BITS]));

  always_comb begin
    if (di_raw < SW'(2) - w_s) begin
      di_d = SW'(2) - w_s;
    end else if (di_raw > w_s - SW'(1)) begin
      di_d = w_s - SW'(1);
    end else begin
      di_d = di_raw;
    end
  end

  assign lo_d = (di_q < SW'(1)) ? SW'(1) - di_q : SW'(0);
  assign hi_d = (di_q > SW'(0)) ? w_s - SW'(1) - di_q : w_s - SW'(1);

  // Requested column clamped into the valid span, then moved by the shift.
  logic signed [SW-1:0] col_s, x_d, sum_d;

  assign col_s = $signed(SW'(column_q));
  assign x_d   = (col_s < lo_q) ? lo_q : ((col_s > hi_q) ? hi_q : col_s);
  assign sum_d = x_d + di_q;

  // Buffer read port: left neighbour first, then right neighbour.
  logic [AW-1:0] raddr;
  logic          re;

  assign raddr = cmd_i.rd_a ? addr_q - AW'(1) : addr_q;
  assign re    = cmd_i.rd_a || cmd_i.rd_b;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[col_ext[AW-1:0]] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Mix written as a + f*(b - a), which floors exactly like the weighted sum.
  logic signed [PW:0]    diff;
  logic signed [PW+15:0] prod_d, step;
  logic [PW-1:0]         res;
  logic [PW+7:0]         res_wide;

  assign diff     = $signed({1'b0, rdata_q}) - $signed({1'b0, a_q});
  assign prod_d   = $signed({1'b0, frac_q}) * diff;
  assign step     = prod_q >>> FRAC_BITS;
  assign res      = a_q + step[PW-1:0];
  assign res_wide = {8'b0, res};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      column_q <= column_i;
      row_q    <= row_i;
    end
    if (cmd_i.mul) begin
      dr_q <= dr_d;
      w_q  <= w_d;
    end
    if (cmd_i.shift) begin
      di_q   <= di_d;
      frac_q <= dr_q[FRAC_BITS-1:0];
    end
    if (cmd_i.bound) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (cmd_i.addr) begin
      addr_q <= sum_d[AW-1:0];
    end
    if (cmd_i.rd_b) begin
      a_q <= rdata_q;
    end
    if (cmd_i.mix) begin
      prod_q <= prod_d;
    end
    if (cmd_i.out_load) begin
      pixel_out_q <= res_wide[PIX_IO_W-1:0];
    end
  end

  assign pixel_out_o = pixel_out_q;

endmodule

`default_nettype wire

### sv/irsi_ctrl.sv
// Controller of the shear interpolation core: sequences a read and runs both handshakes.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module irsi_ctrl import irsi_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  op_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output irsi_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SHIFT,
    S_BOUND,
    S_ADDR,
    S_RDA,
    S_RDB,
    S_MIX,
    S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept, out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = accept;
    cmd_o.load     = accept && !op_i;
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.shift    = (state_q == S_SHIFT);
    cmd_o.bound    = (state_q == S_BOUND);
    cmd_o.addr     = (state_q == S_ADDR);
    cmd_o.rd_a     = (state_q == S_RDA);
    cmd_o.rd_b     = (state_q == S_RDB);
    cmd_o.mix      = (state_q == S_MIX);
    cmd_o.out_load = (state_q == S_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && op_i) begin
            state_q <= S_MUL;
          end
        end
        S_MUL:   state_q <= S_SHIFT;
        S_SHIFT: state_q <= S_BOUND;
        S_BOUND: state_q <= S_ADDR;
        S_ADDR:  state_q <= S_RDA;
        S_RDA:   state_q <= S_RDB;
        S_RDB:   state_q <= S_MIX;
        S_MIX:   state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_NEVER(a_no_overwrite, cmd_o.out_load && out_valid_q && !out_ready_i, "result overwritten")
  `ASSERT_CLK(a_read_blocks, (accept && op_i) |=> !in_ready_o, "word taken during a read")
  `ASSERT_CLK(a_valid_from_load, $rose(out_valid_q) |-> $past(cmd_o.out_load), "stray result")

endmodule

`default_nettype wire

### sv/image_row_shear_interp_core.sv
// Top level of the horizontal shear core with linear interpolation.
`timescale 1ns / 1ps
`default_nettype none

// Horizontal shear of an image row with linear interpolation, one channel.
// A load word (op 0) writes pixel_in_i into the row buffer at column_i and is
// taken without occupying the block, so loads stream at one word per clock
// while no read is in progress; a load to a column at or beyond MAX_WIDTH is
// dropped. A read word (op 1) returns the sheared pixel of column_i in row
// row_i and occupies the block from acceptance until the result sits in the
// output register: one multiply of the row offset by the shear factor, three
// steps of clamping and address forming, two reads through the single read
// port of the row buffer, one interpolation multiply and one step that adds
// the scaled difference to the left neighbour. A new word is taken at the edge
// after that result is registered, even while the result still waits on
// out_ready_i; if the previous result has not been taken, the read holds in
// its last step. Reading a buffer entry that was never loaded gives an
// undefined pixel. The three registers (shear factor, row width, image height)
// are written through the plain write port and must only change while the
// block is idle; the shear factor is saturated to plus or minus one in Q2.14
// as it is written.

module image_row_shear_interp_core import irsi_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   op_i,
  input  wire logic [COL_W-1:0]       column_i,
  input  wire logic [COL_W-1:0]       row_i,
  input  wire logic [PIX_IO_W-1:0]    pixel_in_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [PIX_IO_W-1:0]         pixel_out_o
);

  // Configuration registers. The shear factor is held already saturated so
  // the datapath never sees a tangent larger than one.
  logic signed [SHEAR_W-1:0] shear_q;
  logic [DIM_W-1:0]          width_q, height_q;
  logic signed [SHEAR_W-1:0] shear_wr, shear_sat;

  assign shear_wr = $signed(cfg_wdata_i[SHEAR_W-1:0]);

  always_comb begin
    if (shear_wr > SHEAR_W'(ONE_Q14)) begin
      shear_sat = SHEAR_W'(ONE_Q14);
    end else if (shear_wr < -SHEAR_W'(ONE_Q14)) begin
      shear_sat = -SHEAR_W'(ONE_Q14);
    end else begin
      shear_sat = shear_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shear_q  <= '0;
      width_q  <= DIM_W'(4096);
      height_q <= DIM_W'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHEAR:  shear_q  <= shear_sat;
        CFG_WIDTH:  width_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // The controller owns both handshakes and steps a read one stage per cycle,
  // bar a stall in the last; the datapath holds the buffer and all arithmetic.
  irsi_cmd_t cmd;

  irsi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  irsi_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .column_i       (column_i),
    .row_i          (row_i),
    .pixel_in_i     (pixel_in_i),
    .shear_factor_i (shear_q),
    .row_width_i    (width_q),
    .image_height_i (height_q),
    .pixel_out_o    (pixel_out_o)
  );

endmodule

`default_nettype wire

### tb/tb_image_row_shear_interp_core.sv
// Self-checking testbench for the horizontal shear interpolation core.
`timescale 1ns / 1ps

// The testbench streams load and read words into the core and predicts every
// sheared pixel with its own model of the row buffer and of the three
// registers. A load word updates the local copy of the row; a read word
// computes the shift, picks the two neighbouring taps and queues the
// interpolated pixel, which a checker compares with each word leaving the core.
// The row buffer holds no defined value until written, so every read first
// makes sure that both of the taps it will touch have been loaded.
module tb_image_row_shear_interp_core import irsi_pkg::*; ();

  localparam int MAX_WIDTH    = 4096;
  localparam int PIXEL_BITS   = 8;
  localparam int CLK_HALF     = 6;
  // Idle span used to let a read reach the output register, with slack.
  localparam int READ_LATENCY = 12;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 600;
  localparam int PHASES       = 6;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;
  // Index three has no register behind it; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    int left_col;
    int right_col;
    int frac;
  } shear_taps_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  op_i        = 1'b0;
  logic [COL_W-1:0]      column_i    = '0;
  logic [COL_W-1:0]      row_i       = '0;
  logic [PIX_IO_W-1:0]   pixel_in_i  = '0;
  logic                  out_ready_i = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [PIX_IO_W-1:0]   pixel_out_o;

  // Local copy of the registers, as the core holds them after a write.
  int                    shear_q14  = 0;
  logic [DIM_W-1:0]      width_reg  = 13'd4096;
  logic [DIM_W-1:0]      height_reg = 13'd4096;

  // Local copy of the row buffer and a record of which entries hold data.
  logic [PIX_IO_W-1:0]   row_pix [MAX_WIDTH];
  bit                    loaded  [MAX_WIDTH];

  logic [PIX_IO_W-1:0]   expected_pixels [$];
  int                    error_count  = 0;
  int                    items_sent   = 0;
  int                    quiet_cycles = 0;
  int                    hold_request = 0;
  bit                    idle_en      = 1'b1;

  image_row_shear_interp_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // The row width register is saturated to a usable span when it is used.
  function automatic int eff_width();
    int w;
    w = int'(width_reg);
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  // Works out which two buffer entries a read touches and how it mixes them.
  // The shift is split into its floor and a non-negative fraction, so a
  // negative shift rounds towards minus infinity. An oversized shift is
  // clamped so that exactly one column stays valid, and the requested column
  // is then pulled into the valid span.
  function automatic shear_taps_t shear_taps(input logic [COL_W-1:0] col,
                                             input logic [COL_W-1:0] row);
    longint w, dr, fr, di, lo, hi, x;
    shear_taps_t t;
    w  = longint'(eff_width());
    dr = (longint'(row) - longint'(height_reg >> 1)) * longint'(shear_q14);
    fr = dr & longint'(ONE_Q14 - 1);
    di = (dr - fr) / ONE_Q14;
    if (di < 2 - w) di = 2 - w;
    if (di > w - 1) di = w - 1;
    lo = (1 - di > 0) ? 1 - di : 0;
    hi = (w - 1 - di < w - 1) ? w - 1 - di : w - 1;
    x  = longint'(col);
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    t.left_col  = int'(x + di - 1);
    t.right_col = int'(x + di);
    t.frac      = int'(fr);
    return t;
  endfunction

  // Offers one word and waits for it to be taken. The prediction is made at
  // the edge of acceptance, with the registers and buffer as they stand then.
  task automatic send_word(input logic op, input logic [COL_W-1:0] col,
                           input logic [COL_W-1:0] row, input logic [PIX_IO_W-1:0] pix);
    int gap;
    shear_taps_t t;
    longint mix;
    gap = idle_en ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    column_i   <= col;
    row_i      <= row;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    items_sent++;
    if (op == OP_LOAD) begin
      row_pix[col] = pix;
      loaded[col]  = 1'b1;
    end else begin
      t   = shear_taps(col, row);
      mix = (longint'(t.frac) * longint'(row_pix[t.right_col]) +
             longint'(ONE_Q14 - t.frac) * longint'(row_pix[t.left_col])) >>> FRAC_BITS;
      expected_pixels.push_back(mix[PIX_IO_W-1:0]);
    end
  endtask

  // Reads a sheared pixel, first filling any tap that has never been loaded.
  task automatic read_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row);
    shear_taps_t t;
    t = shear_taps(col, row);
    if (!loaded[t.left_col])
      send_word(OP_LOAD, COL_W'(t.left_col), COL_W'($urandom), PIX_IO_W'($urandom));
    if (!loaded[t.right_col])
      send_word(OP_LOAD, COL_W'(t.right_col), COL_W'($urandom), PIX_IO_W'($urandom));
    send_word(OP_READ, col, row, PIX_IO_W'($urandom));
  endtask

  task automatic load_row(input int n);
    for (int c = 0; c < n; c++)
      send_word(OP_LOAD, COL_W'(c), COL_W'($urandom), PIX_IO_W'($urandom));
  endtask

  // Stops offering words and waits until every predicted pixel has arrived.
  task automatic pause_input();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_pixels.size() != 0);
  endtask

  // Registers may only change while the core is idle: drain the results and
  // then let a read's worth of cycles pass, since loads leave no trace.
  task automatic quiesce();
    pause_input();
    repeat (READ_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    int s;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_SHEAR: begin
        // The shear factor is saturated to plus or minus one as it is written.
        s = int'($signed(data));
        shear_q14 = (s > ONE_Q14) ? ONE_Q14 : ((s < -ONE_Q14) ? -ONE_Q14 : s);
      end
      CFG_WIDTH:  width_reg  = data[DIM_W-1:0];
      CFG_HEIGHT: height_reg = data[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] shear,
                            input logic [CFG_DATA_W-1:0] width,
                            input logic [CFG_DATA_W-1:0] height);
    quiesce();
    write_reg(CFG_SHEAR, shear);
    write_reg(CFG_WIDTH, width);
    write_reg(CFG_HEIGHT, height);
  endtask

  // Columns mostly fall inside or just past the row; now and then anywhere.
  function automatic logic [COL_W-1:0] pick_column();
    int c;
    if ($urandom_range(0, 5) == 0) return COL_W'($urandom);
    c = $urandom_range(0, eff_width() + 3);
    if (c > MAX_WIDTH - 1) c = MAX_WIDTH - 1;
    return COL_W'(c);
  endfunction

  // Rows near the centre give small shifts that leave the span intact; far
  // rows drive the shift into its clamp.
  function automatic logic [COL_W-1:0] pick_row();
    int r;
    if ($urandom_range(0, 3) == 0) return COL_W'($urandom);
    r = int'(height_reg >> 1) + int'($urandom_range(0, 80)) - 40;
    if (r < 0) r = 0;
    if (r > MAX_WIDTH - 1) r = MAX_WIDTH - 1;
    return COL_W'(r);
  endfunction

  // With the reset values the shear is zero and the row is at its widest.
  task automatic test_reset_defaults();
    read_pixel(COL_W'(MAX_WIDTH - 1), '0);
    read_pixel('0, COL_W'(MAX_WIDTH - 1));
  endtask

  // Saturated registers, zero height, the narrowest and widest rows, shifts
  // that overflow the row, columns past the edge and fractional mixing with
  // both positive and negative shifts.
  task automatic test_edge_values();
    write_regs(16'h7FFF, 16'd1, 16'd0);
    write_reg(CFG_SPARE, 16'hFFFF);
    send_word(OP_LOAD, '0, '1, 8'h00);
    send_word(OP_LOAD, 12'd1, '0, 8'hFF);
    read_pixel('0, '0);
    read_pixel('1, '1);
    read_pixel(12'd1, 12'd1);

    write_regs(16'h8000, 16'h1FFF, 16'h1FFF);
    read_pixel('0, '0);
    read_pixel('1, '1);
    read_pixel(12'h800, 12'h7FF);

    write_regs(16'd8192, 16'd8, 16'd9);
    for (int c = 0; c < 8; c++)
      send_word(OP_LOAD, COL_W'(c), '0, c[0] ? 8'hFF : 8'h00);
    read_pixel('0, 12'd5);
    read_pixel(12'd7, 12'd3);
    read_pixel(12'd3, 12'd4);
    read_pixel('1, 12'd3);
  endtask

  // Random registers per phase; mostly row refills followed by bursts of
  // reads, mixed with stray loads, stray reads and pauses.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] shear, width, height;
    int odd_widths [4];
    int target, n;
    odd_widths = '{0, 1, 4096, 8191};
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       shear = 16'h4000;
        1:       shear = 16'hC000;
        2:       shear = '0;
        3:       shear = 16'(int'($urandom_range(0, 2 * ONE_Q14)) - ONE_Q14);
        4:       shear = 16'($urandom);
        default: shear = 16'(int'($urandom_range(0, 4096)) - 2048);
      endcase
      if (phase == 0) shear = 16'h4000;
      if (phase == 1) shear = 16'hC000;
      case ($urandom_range(0, 7))
        5:       width = 16'(odd_widths[$urandom_range(0, 3)]);
        6:       width = 16'($urandom_range(49, MAX_WIDTH));
        7:       width = 16'($urandom);
        default: width = 16'($urandom_range(2, 48));
      endcase
      case ($urandom_range(0, 3))
        0:       height = 16'($urandom_range(1, 4096));
        1:       height = '0;
        2:       height = 16'($urandom);
        default: height = 16'($urandom_range(1, 64));
      endcase
      write_regs(shear, width, height);
      idle_en = (phase % 3 != 0);
      target  = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            n = eff_width();
            if (n > 64) n = $urandom_range(2, 64);
            // Now and then the refill breaks off part way.
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            load_row(n);
            repeat ($urandom_range(4, 16)) read_pixel(pick_column(), pick_row());
          end
          7:       send_word(OP_LOAD, COL_W'($urandom), COL_W'($urandom), PIX_IO_W'($urandom));
          8:       read_pixel(COL_W'($urandom), COL_W'($urandom));
          9: begin
            if ($urandom_range(0, 3) == 0) pause_input();
            else read_pixel(pick_column(), pick_row());
          end
          default: read_pixel(pick_column(), pick_row());
        endcase
      end
    end
    idle_en = 1'b1;
  endtask

  // The sink holds off for a long stretch while reads stream in back to back,
  // so the core fills up and must stall its input.
  task automatic test_output_stall();
    write_regs(16'(int'($urandom_range(0, 4096)) - 2048), 16'd16, 16'd32);
    idle_en = 1'b0;
    load_row(16);
    hold_request = HOLD_CYCLES;
    repeat (40) read_pixel(pick_column(), pick_row());
    pause_input();
    idle_en = 1'b1;
  endtask

  // Result sink: draws a wait before each word, or takes the long hold-off
  // when one has been asked for.
  initial begin : result_sink
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = idle_en ? $urandom_range(0, 19) : 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Each word leaving the core is matched against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    logic [PIX_IO_W-1:0] want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel_out: expected no word, actual %0d", pixel_out_o);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_out_o !== want) begin
          $error("pixel_out: expected %0d, actual %0d", want, pixel_out_o);
          error_count++;
        end
      end
    end
  end

  // Counts cycles in which no word moves on either side and no register is
  // written.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o === 1'b1) ||
        (out_valid_o === 1'b1 && out_ready_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_edge_values();
    test_random_traffic();
    test_output_stall();
    pause_input();
    repeat (READ_LATENCY) @(posedge clk_i);
    if (error_count == 0 && expected_pixels.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/irsi_pkg.sv
sv/irsi_dpath.sv
sv/irsi_ctrl.sv
sv/image_row_shear_interp_core.sv
tb/tb_image_row_shear_interp_core.sv
